// ===== rtl/hsl_to_rgb12_pixel_top_macros.svh =====
// assertion macros shared by the rtl files
`ifndef HSL_TO_RGB12_PIXEL_TOP_MACROS_SVH
`define HSL_TO_RGB12_PIXEL_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define HSL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("hsl rgb assertion failed");
`define HSL_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("hsl rgb assertion failed");
`else
`define HSL_ASSERT(lbl, clk, rstn, prop)
`define HSL_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ===== rtl/hslrgb_pkg.sv =====
`default_nettype none
package hslrgb_pkg;

  localparam int unsigned PIXEL_COUNT_DEF = 1024;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [15:0] ONE15      = 16'd32768;
  localparam logic [15:0] HALF15     = 16'd16384;
  localparam logic [17:0] TURN6      = 18'd196608;
  localparam logic [17:0] THIRD6     = 18'd65536;
  localparam logic [17:0] TWO_THIRD6 = 18'd131072;
  localparam logic [17:0] SIXTH_END  = 18'd32768;
  localparam logic [17:0] HALF_END   = 18'd98304;
  localparam logic [17:0] FALL_END   = 18'd131072;

  typedef struct packed {
    logic [9:0]  pixel_index;
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [15:0] lightness;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  pixel_slot;
    logic [11:0] red_level;
    logic [11:0] green_level;
    logic [11:0] blue_level;
  } out_item_t;

  // classified pixel: clamped s/l and per-channel ramp weights
  typedef struct packed {
    logic [9:0]  idx;
    logic [15:0] sat;
    logic [15:0] light;
    logic [15:0] f_r;
    logic [15:0] f_g;
    logic [15:0] f_b;
  } work_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [15:0] clamp_one(input logic [15:0] v);
    return (v > ONE15) ? ONE15 : v;
  endfunction

  // weight f in 0..32768 for hue position 6t
  function automatic logic [15:0] ramp_weight(input logic [17:0] t6);
    logic [17:0] diff;
    logic [15:0] f;
    diff = FALL_END - t6;
    if (t6 < SIXTH_END) begin
      f = t6[15:0];
    end else if (t6 < HALF_END) begin
      f = ONE15;
    end else if (t6 < FALL_END) begin
      f = diff[15:0];
    end else begin
      f = '0;
    end
    return f;
  endfunction

  // floor(c*4095/255) = 16c + floor(c/17), c/17 via reciprocal 241/4096
  function automatic logic [11:0] widen12(input logic [7:0] c);
    logic [15:0] m;
    m = 16'(c) * 16'd241;
    return {c, 4'b0000} + 12'(m[15:12]);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hslrgb_stream_if.sv =====
`default_nettype none
interface hslrgb_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/hsl_to_rgb12_pixel_top.sv =====
// channel | dir | payload                                           | beat when
// in_i    | in  | pixel_index, hue, saturation, lightness           | valid & ready
// out_o   | out | pixel_slot, red_level, green_level, blue_level    | valid & ready
//
// one pixel per clock sustained while out_o is ready; a beat taken into an empty queue passes
// through the queue, then six back stages (three 31x16 multipliers), before it shows on out_o
// pixels at or above PIXEL_COUNT are taken and give no output beat
// reset clears the queue pointers, count and stage valids only; no clearing pass
// in_i.ready drops only when the queue is full, so a stalled out_o stalls
// the input after the pipeline and the queue have filled
`default_nettype none
module hsl_to_rgb12_pixel_top #(
  parameter int unsigned PIXEL_COUNT = hslrgb_pkg::PIXEL_COUNT_DEF,
  parameter int unsigned QUEUE_DEPTH = hslrgb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  hslrgb_stream_if.sink   in_i,
  hslrgb_stream_if.source out_o
);

  logic                    push;
  logic                    pop;
  hslrgb_pkg::work_item_t  push_item;
  hslrgb_pkg::work_item_t  head_item;
  hslrgb_pkg::queue_stat_t stat;

  hslrgb_front #(
    .PIXEL_COUNT(PIXEL_COUNT)
  ) u_front (
    .in_i   (in_i),
    .stat_i (stat),
    .push_o (push),
    .item_o (push_item)
  );

  hslrgb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (stat)
  );

  hslrgb_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .item_i (head_item),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire

// ===== rtl/hslrgb_front.sv =====
`default_nettype none
module hslrgb_front #(
  parameter int unsigned PIXEL_COUNT = hslrgb_pkg::PIXEL_COUNT_DEF
) (
  hslrgb_stream_if.sink             in_i,
  input  hslrgb_pkg::queue_stat_t   stat_i,
  output logic                      push_o,
  output hslrgb_pkg::work_item_t    item_o
);

  logic [14:0] hue15;
  logic [17:0] t_g;
  logic [17:0] t_r_sum;
  logic [17:0] t_r;
  logic [17:0] t_b;
  logic        in_range;

  assign hue15   = in_i.data.hue[14:0];
  // 6h as 4h + 2h
  assign t_g     = {1'b0, hue15, 2'b00} + {2'b00, hue15, 1'b0};
  assign t_r_sum = t_g + hslrgb_pkg::THIRD6;
  assign t_r     = (t_r_sum >= hslrgb_pkg::TURN6) ? (t_r_sum - hslrgb_pkg::TURN6) : t_r_sum;
  assign t_b     = (t_g >= hslrgb_pkg::THIRD6) ? (t_g - hslrgb_pkg::THIRD6)
                                               : (t_g + hslrgb_pkg::TWO_THIRD6);

  assign in_range = {7'b0, in_i.data.pixel_index} < 17'(PIXEL_COUNT);

  assign in_i.ready = !stat_i.full;
  // out-of-range pixels are taken and dropped here
  assign push_o     = in_i.valid && !stat_i.full && in_range;

  always_comb begin
    item_o.idx   = in_i.data.pixel_index;
    item_o.sat   = hslrgb_pkg::clamp_one(in_i.data.saturation);
    item_o.light = hslrgb_pkg::clamp_one(in_i.data.lightness);
    item_o.f_r   = hslrgb_pkg::ramp_weight(t_r);
    item_o.f_g   = hslrgb_pkg::ramp_weight(t_g);
    item_o.f_b   = hslrgb_pkg::ramp_weight(t_b);
  end

endmodule
`default_nettype wire

// ===== rtl/hslrgb_queue.sv =====
`default_nettype none
`include "hsl_to_rgb12_pixel_top_macros.svh"
module hslrgb_queue #(
  parameter int unsigned DEPTH = hslrgb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  hslrgb_pkg::work_item_t    item_i,
  input  logic                      pop_i,
  output hslrgb_pkg::work_item_t    item_o,
  output hslrgb_pkg::queue_stat_t   stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  hslrgb_pkg::work_item_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign stat_o.full  = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `HSL_ASSERT(a_push_has_room, clk_i, rst_ni, push_i |-> !stat_o.full)
  `HSL_ASSERT(a_pop_has_beat, clk_i, rst_ni, pop_i |-> !stat_o.empty)
  `HSL_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(DEPTH))

endmodule
`default_nettype wire

// ===== rtl/hslrgb_back.sv =====
`default_nettype none
`include "hsl_to_rgb12_pixel_top_macros.svh"
module hslrgb_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hslrgb_pkg::queue_stat_t   stat_i,
  input  hslrgb_pkg::work_item_t    item_i,
  output logic                      pop_o,
  hslrgb_stream_if.source           out_o
);

  localparam int unsigned NSTAGE = 6;

  logic [NSTAGE:1]   v_q;
  logic [NSTAGE:1]   v_in;
  logic [NSTAGE+1:1] rdy;

  // stage 1: l*s
  logic [9:0]  idx1_q, idx2_q, idx3_q, idx4_q, idx5_q;
  logic [15:0] l1_q, s1_q;
  logic [15:0] fr1_q, fg1_q, fb1_q, fr2_q, fg2_q, fb2_q;
  logic [31:0] ls1_q;
  // stage 2: q, p, d in Q30
  logic [31:0] l30, s30, l31, q_sum, p_sum;
  logic [30:0] q30, p30, d30;
  logic [30:0] p2_q, d2_q, p3_q;
  // stage 3: d*f
  logic [46:0] pr_r, pr_g, pr_b;
  logic [45:0] pr3_r_q, pr3_g_q, pr3_b_q;
  // stage 4: num = p*2^15 + d*f
  logic [45:0] n4_r_q, n4_g_q, n4_b_q;
  // stage 5: 8-bit levels
  logic [53:0] t_r, t_g, t_b;
  logic [7:0]  c_r_q, c_g_q, c_b_q;
  hslrgb_pkg::out_item_t out_q;

  always_comb begin
    rdy[NSTAGE+1] = out_o.ready;
    for (int k = NSTAGE; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    v_in[1] = !stat_i.empty;
    for (int k = 2; k <= NSTAGE; k++) begin
      v_in[k] = v_q[k-1];
    end
  end

  assign pop_o       = !stat_i.empty && rdy[1];
  assign out_o.valid = v_q[NSTAGE];
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NSTAGE; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      idx1_q <= item_i.idx;
      l1_q   <= item_i.light;
      s1_q   <= item_i.sat;
      fr1_q  <= item_i.f_r;
      fg1_q  <= item_i.f_g;
      fb1_q  <= item_i.f_b;
      ls1_q  <= item_i.light * item_i.sat;
    end
  end

  // saturation of zero gives q = p = l, so gray needs no path of its own
  always_comb begin
    l30   = {1'b0, l1_q, 15'b0};
    s30   = {1'b0, s1_q, 15'b0};
    l31   = {l1_q, 16'b0};
    q_sum = (l1_q < hslrgb_pkg::HALF15) ? (l30 + ls1_q) : (l30 + s30 - ls1_q);
    q30   = q_sum[30:0];
    p_sum = l31 - {1'b0, q30};
    p30   = p_sum[30:0];
    d30   = q30 - p30;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      idx2_q <= idx1_q;
      p2_q   <= p30;
      d2_q   <= d30;
      fr2_q  <= fr1_q;
      fg2_q  <= fg1_q;
      fb2_q  <= fb1_q;
    end
  end

  assign pr_r = d2_q * fr2_q;
  assign pr_g = d2_q * fg2_q;
  assign pr_b = d2_q * fb2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      idx3_q  <= idx2_q;
      p3_q    <= p2_q;
      pr3_r_q <= pr_r[45:0];
      pr3_g_q <= pr_g[45:0];
      pr3_b_q <= pr_b[45:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      idx4_q <= idx3_q;
      n4_r_q <= {p3_q, 15'b0} + pr3_r_q;
      n4_g_q <= {p3_q, 15'b0} + pr3_g_q;
      n4_b_q <= {p3_q, 15'b0} + pr3_b_q;
    end
  end

  // num*255 as num*256 - num, level is bits 52:45
  assign t_r = {n4_r_q, 8'b0} - {8'b0, n4_r_q};
  assign t_g = {n4_g_q, 8'b0} - {8'b0, n4_g_q};
  assign t_b = {n4_b_q, 8'b0} - {8'b0, n4_b_q};

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      idx5_q <= idx4_q;
      c_r_q  <= t_r[52:45];
      c_g_q  <= t_g[52:45];
      c_b_q  <= t_b[52:45];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      out_q.pixel_slot  <= idx5_q;
      out_q.red_level   <= hslrgb_pkg::widen12(c_r_q);
      out_q.green_level <= hslrgb_pkg::widen12(c_g_q);
      out_q.blue_level  <= hslrgb_pkg::widen12(c_b_q);
    end
  end

  `HSL_ASSERT_NEXT(a_stall_keeps_level, clk_i, rst_ni, v_q[5] && !rdy[5], v_q[5] && $stable(c_r_q))
  `HSL_ASSERT(a_pop_needs_room, clk_i, rst_ni, pop_o |-> (!v_q[1] || rdy[2]))

endmodule
`default_nettype wire

// ===== dv/hsl_to_rgb12_pixel_checker.sv =====
`timescale 1ns / 100ps
module hsl_to_rgb12_pixel_checker
  import hslrgb_pkg::*;
#(
  parameter int unsigned PIXEL_COUNT = PIXEL_COUNT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  output int        fail_cnt_o,
  output int        rgb_due_o,
  output int        rgb_checked_o
);

  localparam logic [63:0] UNIT      = 64'd32768;
  localparam logic [63:0] HUE_TURN  = 64'd196608;
  localparam logic [63:0] HUE_THIRD = 64'd65536;

  out_item_t rgb_due_q[$];
  int err_cnt = 0;
  int due_cnt = 0;
  int checked_cnt = 0;

  assign fail_cnt_o    = err_cnt;
  assign rgb_due_o     = due_cnt;
  assign rgb_checked_o = checked_cnt;

  function automatic logic [63:0] sat_unit(input logic [15:0] v);
    return (64'(v) > UNIT) ? UNIT : 64'(v);
  endfunction

  // 8-bit level at hue position t6 (six times the hue, 2^-15 units)
  function automatic logic [7:0] ramp_level8(input logic [63:0] p30, input logic [63:0] d30,
                                             input logic [63:0] t6);
    logic [63:0] f;
    logic [63:0] num;
    logic [63:0] c;
    if (t6 < UNIT) begin
      f = t6;
    end else if (t6 < 3 * UNIT) begin
      f = UNIT;
    end else if (t6 < 4 * UNIT) begin
      f = 4 * UNIT - t6;
    end else begin
      f = '0;
    end
    num = p30 * UNIT + d30 * f;
    c   = (num * 64'd255) >> 45;
    return (c > 64'd255) ? 8'd255 : c[7:0];
  endfunction

  function automatic logic [11:0] level12(input logic [7:0] c8);
    logic [63:0] w;
    w = (64'(c8) * 64'd4095) / 64'd255;
    return w[11:0];
  endfunction

  function automatic out_item_t pixel_rgb12(input in_item_t px);
    logic [63:0] h, s, l, q30, p30, d30, tg, tr, tb, gray;
    logic [7:0]  r8, g8, b8;
    out_item_t   rgb;
    h = 64'(px.hue[14:0]);
    s = sat_unit(px.saturation);
    l = sat_unit(px.lightness);
    if (s == 0) begin
      gray = (l * 64'd255) >> 15;
      r8 = gray[7:0];
      g8 = r8;
      b8 = r8;
    end else begin
      if (l < UNIT / 2) begin
        q30 = l * UNIT + l * s;
      end else begin
        q30 = l * UNIT + s * UNIT - l * s;
      end
      p30 = 2 * l * UNIT - q30;
      d30 = q30 - p30;
      tg  = h * 6;
      tr  = (tg + HUE_THIRD) % HUE_TURN;
      tb  = (tg + HUE_TURN - HUE_THIRD) % HUE_TURN;
      r8  = ramp_level8(p30, d30, tr);
      g8  = ramp_level8(p30, d30, tg);
      b8  = ramp_level8(p30, d30, tb);
    end
    rgb.pixel_slot  = px.pixel_index;
    rgb.red_level   = level12(r8);
    rgb.green_level = level12(g8);
    rgb.blue_level  = level12(b8);
    return rgb;
  endfunction

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (rgb_due_q.size() == 0) begin
          if (err_cnt < 10) begin
            $display("%0t: unexpected colour beat slot=%0d r=%0d g=%0d b=%0d", $time,
                     out_data_i.pixel_slot, out_data_i.red_level, out_data_i.green_level,
                     out_data_i.blue_level);
          end
          err_cnt <= err_cnt + 1;
        end else begin
          want = rgb_due_q.pop_front();
          checked_cnt <= checked_cnt + 1;
          if (out_data_i.pixel_slot !== want.pixel_slot ||
              out_data_i.red_level !== want.red_level ||
              out_data_i.green_level !== want.green_level ||
              out_data_i.blue_level !== want.blue_level) begin
            if (err_cnt < 10) begin
              $display("%0t: colour mismatch exp slot=%0d r=%0d g=%0d b=%0d", $time,
                       want.pixel_slot, want.red_level, want.green_level, want.blue_level);
              $display("%0t:                 got slot=%0d r=%0d g=%0d b=%0d", $time,
                       out_data_i.pixel_slot, out_data_i.red_level,
                       out_data_i.green_level, out_data_i.blue_level);
            end
            err_cnt <= err_cnt + 1;
          end
        end
      end
      // pixels past the strip end are swallowed
      if (in_valid_i && in_ready_i && 32'(in_data_i.pixel_index) < PIXEL_COUNT) begin
        rgb_due_q.push_back(pixel_rgb12(in_data_i));
      end
      due_cnt <= rgb_due_q.size();
    end
  end

endmodule

// ===== dv/tb_hsl_to_rgb12_pixel_top.sv =====
`timescale 1ns / 100ps
module tb_hsl_to_rgb12_pixel_top;
  import hslrgb_pkg::*;

  localparam int RANDOM_PIXELS = 1080;
  localparam int LONG_HOLD     = 300;

  logic clk_i = 1'b0;
  logic rst_ni;

  hslrgb_stream_if #(.payload_t(in_item_t))  pix_in_if ();
  hslrgb_stream_if #(.payload_t(out_item_t)) rgb_out_if ();

  int  fail_cnt;
  int  rgb_due;
  int  rgb_checked;
  int  sent_cnt = 0;
  int  directed_cnt = 0;
  bit  quiet = 1'b0;
  bit  long_hold_req = 1'b0;

  hsl_to_rgb12_pixel_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pix_in_if),
    .out_o  (rgb_out_if)
  );

  hsl_to_rgb12_pixel_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (pix_in_if.valid),
    .in_ready_i    (pix_in_if.ready),
    .in_data_i     (pix_in_if.data),
    .out_valid_i   (rgb_out_if.valid),
    .out_ready_i   (rgb_out_if.ready),
    .out_data_i    (rgb_out_if.data),
    .fail_cnt_o    (fail_cnt),
    .rgb_due_o     (rgb_due),
    .rgb_checked_o (rgb_checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // colour sink: random back-pressure, one long hold on request
  initial begin
    rgb_out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rgb_out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        rgb_out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        rgb_out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
    end
  end

  function automatic logic [15:0] pick_unit(input int unsigned edge_odds);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < edge_odds) begin
      case ($urandom_range(0, 3))
        0:       return 16'd0;
        1:       return 16'd32768;
        2:       return 16'd16384;
        default: return 16'd16383;
      endcase
    end else if (roll < edge_odds + 2) begin
      return 16'($urandom());
    end
    return 16'($urandom_range(0, 32768));
  endfunction

  function automatic in_item_t random_pixel();
    in_item_t px;
    px.pixel_index = 10'($urandom_range(0, 1023));
    px.hue         = ($urandom_range(0, 9) == 0) ? 16'($urandom())
                                                 : 16'($urandom_range(0, 32768));
    px.saturation  = pick_unit(4);
    px.lightness   = pick_unit(4);
    return px;
  endfunction

  task automatic send_pixel(input in_item_t px);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      pix_in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    pix_in_if.valid <= 1'b1;
    pix_in_if.data  <= px;
    do @(posedge clk_i); while (pix_in_if.ready !== 1'b1);
    sent_cnt++;
  endtask

  task automatic drain_colours();
    pix_in_if.valid <= 1'b0;
    do @(posedge clk_i); while (rgb_due != 0);
  endtask

  initial begin
    pix_in_if.valid <= 1'b0;
    pix_in_if.data  <= '0;
    rst_ni          <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // grays, primaries, sector edges, wrap and clamp of out-of-range fields
    send_pixel(in_item_t'{10'd0,    16'd0,     16'd0,     16'd0});
    send_pixel(in_item_t'{10'd1023, 16'd0,     16'd0,     16'd32768});
    send_pixel(in_item_t'{10'd5,    16'd12345, 16'd0,     16'd16384});
    send_pixel(in_item_t'{10'd6,    16'd0,     16'd32768, 16'd16384});
    send_pixel(in_item_t'{10'd7,    16'd10923, 16'd32768, 16'd16384});
    send_pixel(in_item_t'{10'd8,    16'd21845, 16'd32768, 16'd16384});
    send_pixel(in_item_t'{10'd9,    16'd32768, 16'd32768, 16'd16384});
    send_pixel(in_item_t'{10'd10,   16'd65535, 16'd65535, 16'd65535});
    send_pixel(in_item_t'{10'd11,   16'd5461,  16'd32768, 16'd16384});
    send_pixel(in_item_t'{10'd12,   16'd5462,  16'd32768, 16'd16384});
    send_pixel(in_item_t'{10'd13,   16'd16384, 16'd32768, 16'd16384});
    send_pixel(in_item_t'{10'd14,   16'd27307, 16'd32768, 16'd16384});
    send_pixel(in_item_t'{10'd15,   16'd32767, 16'd1,     16'd16383});
    send_pixel(in_item_t'{10'd16,   16'd1000,  16'd32768, 16'd32768});
    send_pixel(in_item_t'{10'd17,   16'd20000, 16'd1,     16'd1});
    send_pixel(in_item_t'{10'd18,   16'd8000,  16'd20000, 16'd16384});
    send_pixel(in_item_t'{10'd19,   16'd8000,  16'd20000, 16'd16383});
    send_pixel(in_item_t'{10'd20,   16'd30000, 16'd32769, 16'd24000});
    send_pixel(in_item_t'{10'd21,   16'd3000,  16'd12000, 16'd32769});
    send_pixel(in_item_t'{10'd512,  16'd45000, 16'd40000, 16'd10000});
    send_pixel(in_item_t'{10'd1023, 16'd32768, 16'd0,     16'd65535});
    directed_cnt = sent_cnt;
    drain_colours();

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i == 300) long_hold_req = 1'b1;
      if (i == 600) drain_colours();
      if (i == 900) quiet = 1'b1;
      send_pixel(random_pixel());
    end

    drain_colours();
    repeat (20) @(posedge clk_i);
    $display("sent %0d pixels (%0d directed, rest random), %0d colour beats checked",
             sent_cnt, directed_cnt, rgb_checked);
    $display("covered gray, all hue sectors, wrap and clamp, long sink hold, drain pause");
    if (fail_cnt == 0 && rgb_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hslrgb_pkg.sv
rtl/hslrgb_stream_if.sv
rtl/hslrgb_front.sv
rtl/hslrgb_queue.sv
rtl/hslrgb_back.sv
rtl/hsl_to_rgb12_pixel_top.sv
dv/hsl_to_rgb12_pixel_checker.sv
dv/tb_hsl_to_rgb12_pixel_top.sv
